[rtl/core/ata_tf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_pkg
// Shared types and constants for the ATA task-file address builder: request,
// result and drive configuration records, addressing modes, register indexes
// and command opcodes.
// ----------------------------------------------------------------------------
package ata_tf_pkg;

   localparam int NUM_DRIVES = 4;
   localparam int DRV_W      = 2;
   localparam int LBA_W      = 32;
   localparam int CHS_LBA_W  = 28;   // CHS and LBA28 only see addresses below 2^28
   localparam int QUOT_W     = 23;   // floor((2^28 - 1) / 63) fits in 23 bits
   localparam int CYL_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Divide by 63 through a reciprocal: q = (lba * DIV63_RECIP) >> DIV63_SHIFT.
   // The rounding error of the ceiling reciprocal (47) stays under 2^6, so the
   // quotient is exact for every 28-bit dividend.
   localparam int                DIV63_SHIFT = 34;
   localparam int                RECIP_W     = 29;
   localparam logic [RECIP_W-1:0] DIV63_RECIP = 29'd272696337;
   localparam int                PROD_W      = CHS_LBA_W + RECIP_W;

   // Device/head byte bases
   localparam logic [7:0] DEVSEL_CHS = 8'hA0;
   localparam logic [7:0] DEVSEL_LBA = 8'hE0;

   // PIO and flush opcodes
   localparam logic [7:0] OPC_READ      = 8'h20;
   localparam logic [7:0] OPC_READ_EXT  = 8'h24;
   localparam logic [7:0] OPC_WRITE     = 8'h30;
   localparam logic [7:0] OPC_WRITE_EXT = 8'h34;
   localparam logic [7:0] OPC_FLUSH     = 8'hE7;
   localparam logic [7:0] OPC_FLUSH_EXT = 8'hEA;
   localparam logic [7:0] OPC_NONE      = 8'h00;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_MASK   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LBA_MASK     = 2'd2;

   // Configuration reset values
   localparam logic [NUM_DRIVES-1:0] CHANNEL_MASK_RST = 4'd12;
   localparam logic [NUM_DRIVES-1:0] SLAVE_MASK_RST   = 4'd10;
   localparam logic [NUM_DRIVES-1:0] LBA_MASK_RST     = 4'd0;

   typedef enum logic [1:0] {
      MODE_CHS   = 2'd0,
      MODE_LBA28 = 2'd1,
      MODE_LBA48 = 2'd2
   } mode_type;

   typedef struct packed {
      logic [NUM_DRIVES-1:0] channel_mask;
      logic [NUM_DRIVES-1:0] slave_mask;
      logic [NUM_DRIVES-1:0] lba_mask;
   } cfg_type;

   typedef struct packed {
      logic [LBA_W-1:0] block_address;
      logic [7:0]       sector_count;
      logic             is_write;
      logic [DRV_W-1:0] drive_index;
   } req_type;

   typedef struct packed {
      logic [1:0] address_mode;
      logic       channel_select;
      logic [7:0] device_select;
      logic [7:0] count_byte;
      logic [7:0] address_byte0;
      logic [7:0] address_byte1;
      logic [7:0] address_byte2;
      logic [7:0] address_byte3;
      logic [7:0] command_opcode;
      logic [7:0] flush_opcode;
   } rsp_type;

endpackage

[rtl/core/ata_tf_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_ifs
// Valid/ready channels of the task-file address builder: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface ata_tf_req_if import ata_tf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LBA_W-1:0] block_address;
   logic [7:0]       sector_count;
   logic             is_write;
   logic [DRV_W-1:0] drive_index;

   modport source (output valid, block_address, sector_count, is_write, drive_index,
                   input ready);
   modport sink   (input valid, block_address, sector_count, is_write, drive_index,
                   output ready);
endinterface

interface ata_tf_rsp_if import ata_tf_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] address_mode;
   logic       channel_select;
   logic [7:0] device_select;
   logic [7:0] count_byte;
   logic [7:0] address_byte0;
   logic [7:0] address_byte1;
   logic [7:0] address_byte2;
   logic [7:0] address_byte3;
   logic [7:0] command_opcode;
   logic [7:0] flush_opcode;

   modport source (output valid, address_mode, channel_select, device_select, count_byte,
                   address_byte0, address_byte1, address_byte2, address_byte3,
                   command_opcode, flush_opcode,
                   input ready);
   modport sink   (input valid, address_mode, channel_select, device_select, count_byte,
                   address_byte0, address_byte1, address_byte2, address_byte3,
                   command_opcode, flush_opcode,
                   output ready);
endinterface

interface ata_tf_csr_if import ata_tf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ata_tf_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_csr
// Per-drive configuration registers: channel, slave and LBA support masks.
// Writes are always taken; an index past the last register is dropped.
// ----------------------------------------------------------------------------
module ata_tf_csr import ata_tf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ata_tf_csr_if.sink   csr_chan,
   output cfg_type      cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_chan.index)
            CSR_CHANNEL_MASK: cfg_in.channel_mask = csr_chan.data;
            CSR_SLAVE_MASK:   cfg_in.slave_mask   = csr_chan.data;
            CSR_LBA_MASK:     cfg_in.lba_mask     = csr_chan.data;
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_mask <= CHANNEL_MASK_RST;
         cfg_ff.slave_mask   <= SLAVE_MASK_RST;
         cfg_ff.lba_mask     <= LBA_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/ata_tf_xlate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_tf_xlate
// Address translation: picks CHS, LBA28 or LBA48 and forms the task-file
// bytes, device/head byte and opcodes for one request.
// ----------------------------------------------------------------------------
module ata_tf_xlate import ata_tf_pkg::*; (
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   logic                 is_lba48;
   logic                 chan;
   logic                 slave;
   logic                 has_lba;
   logic [CHS_LBA_W-1:0] lba28;
   logic [PROD_W-1:0]    prod;
   logic [QUOT_W-1:0]    track;
   logic [CHS_LBA_W-1:0] track_x63;
   logic [CHS_LBA_W-1:0] rem;
   logic [CYL_W-1:0]     cyl;
   logic [3:0]           head;
   mode_type             mode;

   assign is_lba48 = (req.block_address[LBA_W-1:CHS_LBA_W] != '0);
   assign chan     = cfg.channel_mask[req.drive_index];
   assign slave    = cfg.slave_mask[req.drive_index];
   assign has_lba  = cfg.lba_mask[req.drive_index];
   assign lba28    = req.block_address[CHS_LBA_W-1:0];

   // CHS geometry: track = lba / 63 by reciprocal, remainder by shift-subtract
   assign prod      = PROD_W'(lba28) * PROD_W'(DIV63_RECIP);
   assign track     = prod[DIV63_SHIFT +: QUOT_W];
   assign track_x63 = CHS_LBA_W'({track, 6'b0} - {6'b0, track});
   assign rem       = lba28 - track_x63;
   // lba / 1008 is track / 16; cylinder wraps to 16 bits
   assign cyl       = track[4 +: CYL_W];

   // Mode select and head nibble
   always_comb begin
      if (is_lba48) begin
         mode = MODE_LBA48;
         head = 4'd0;
      end else if (has_lba) begin
         mode = MODE_LBA28;
         head = req.block_address[27:24];
      end else begin
         mode = MODE_CHS;
         head = track[3:0];
      end
   end

   // Task-file bytes and opcodes
   always_comb begin
      rsp                = '0;
      rsp.address_mode   = mode;
      rsp.channel_select = chan;
      rsp.count_byte     = req.sector_count;
      rsp.device_select  = ((mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA)
                           | {3'b000, slave, head};
      case (mode)
         MODE_CHS: begin
            rsp.address_byte0 = 8'(rem[5:0]) + 8'd1;
            rsp.address_byte1 = cyl[7:0];
            rsp.address_byte2 = cyl[15:8];
            rsp.address_byte3 = 8'd0;
         end
         MODE_LBA28: begin
            rsp.address_byte0 = req.block_address[7:0];
            rsp.address_byte1 = req.block_address[15:8];
            rsp.address_byte2 = req.block_address[23:16];
            rsp.address_byte3 = 8'd0;
         end
         MODE_LBA48: begin
            rsp.address_byte0 = req.block_address[7:0];
            rsp.address_byte1 = req.block_address[15:8];
            rsp.address_byte2 = req.block_address[23:16];
            rsp.address_byte3 = req.block_address[31:24];
         end
         default: begin
            rsp.address_byte0 = 8'd0;
            rsp.address_byte1 = 8'd0;
            rsp.address_byte2 = 8'd0;
            rsp.address_byte3 = 8'd0;
         end
      endcase
      if (mode == MODE_LBA48) begin
         rsp.command_opcode = req.is_write ? OPC_WRITE_EXT : OPC_READ_EXT;
         rsp.flush_opcode   = req.is_write ? OPC_FLUSH_EXT : OPC_NONE;
      end else begin
         rsp.command_opcode = req.is_write ? OPC_WRITE : OPC_READ;
         rsp.flush_opcode   = req.is_write ? OPC_FLUSH : OPC_NONE;
      end
   end

endmodule

[rtl/core/ata_taskfile_address_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_taskfile_address_builder
// Turns a block request into ATA task-file register bytes, device/head byte,
// PIO command and cache-flush opcodes.
// ----------------------------------------------------------------------------
// Each request yields exactly one result: the request is captured in an
// input register, translated in one pass (the divide-by-63 reciprocal
// multiply for CHS sets the path), and held in a result register. A new
// request is taken every cycle while results drain; a stalled result holds
// both stages. Addresses at or above 2^28 use LBA48, otherwise LBA-capable
// drives use LBA28 and all others CHS (16 heads, 63 sectors per track,
// cylinder wrapped to 16 bits). The user writes drive configuration through
// the csr channel only while no request is in flight; the block does not
// enforce it. Writes are always accepted and need no clearing after reset.
module ata_taskfile_address_builder import ata_tf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ata_tf_req_if.sink   req_chan,
   ata_tf_rsp_if.source rsp_chan,
   ata_tf_csr_if.sink   csr_chan
);

   cfg_type cfg;
   req_type req_pay;
   rsp_type xlate_rsp;

   logic    s1_vld_ff, s1_vld_in;
   req_type s1_req_ff, s1_req_in;
   logic    rsp_vld_ff, rsp_vld_in;
   rsp_type rsp_ff, rsp_in;

   logic    out_free;
   logic    s1_adv;
   logic    req_rdy;
   logic    req_acc;

   ata_tf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   ata_tf_xlate u_xlate (
      .req (s1_req_ff),
      .cfg (cfg),
      .rsp (xlate_rsp)
   );

   // Handshake: result slot free, stage advance, request ready
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;
   assign s1_adv         = s1_vld_ff && out_free;
   assign req_rdy        = !s1_vld_ff || out_free;
   assign req_acc        = req_chan.valid && req_rdy;
   assign req_chan.ready = req_rdy;

   assign req_pay.block_address = req_chan.block_address;
   assign req_pay.sector_count  = req_chan.sector_count;
   assign req_pay.is_write      = req_chan.is_write;
   assign req_pay.drive_index   = req_chan.drive_index;

   // Next-state for both stages
   assign s1_vld_in  = req_acc || (s1_vld_ff && !out_free);
   assign s1_req_in  = req_acc ? req_pay : s1_req_ff;
   assign rsp_vld_in = s1_adv || (rsp_vld_ff && !rsp_chan.ready);
   assign rsp_in     = s1_adv ? xlate_rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   // Result channel
   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.address_mode   = rsp_ff.address_mode;
   assign rsp_chan.channel_select = rsp_ff.channel_select;
   assign rsp_chan.device_select  = rsp_ff.device_select;
   assign rsp_chan.count_byte     = rsp_ff.count_byte;
   assign rsp_chan.address_byte0  = rsp_ff.address_byte0;
   assign rsp_chan.address_byte1  = rsp_ff.address_byte1;
   assign rsp_chan.address_byte2  = rsp_ff.address_byte2;
   assign rsp_chan.address_byte3  = rsp_ff.address_byte3;
   assign rsp_chan.command_opcode = rsp_ff.command_opcode;
   assign rsp_chan.flush_opcode   = rsp_ff.flush_opcode;

`ifndef SYNTHESIS
   // A request in the input stage that cannot move on stays put
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_free) |=> (s1_vld_ff && $stable(s1_req_ff)))
      else $error("input stage lost or changed a stalled request");

   // Every advance lands in the result register
   a_adv_lands: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_vld_ff)
      else $error("advanced request missing from result register");

   // CHS sector number is 1..63 and the top address byte is clear
   a_chs_sector: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_ff.address_mode == MODE_CHS)) |->
         ((rsp_ff.address_byte0 != 8'd0) && (rsp_ff.address_byte0 <= 8'd63)
          && (rsp_ff.address_byte3 == 8'd0)))
      else $error("CHS sector number out of range");
`endif

endmodule
